// File: hw/rtl/pit_pkg.sv
// Shared types and constants for the barycentric point-in-triangle block.
// Holds the input/result beat structs and the fixed-point output format.
// No dependencies.
`timescale 1ns / 1ps

package pit_pkg;

  // Result format: signed Q3.16
  localparam int unsigned QW    = 20;
  localparam int unsigned FracW = 16;
  // Integer quotient bits produced before rounding (u, v < 2^(QW-FracW+1))
  localparam int unsigned QuoW  = QW + 1;
  // Divider latency: prepare stage, one stage per quotient bit, round stage
  localparam int unsigned DivLat = QuoW + 2;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
  // Largest magnitude that a negative result can carry unsaturated
  localparam int unsigned QNegMag = 2 ** (QW - 1);

  // Queue depths (powers of two)
  localparam int unsigned MidDepth = 8;
  localparam int unsigned OutDepth = 32;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_a_z;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_b_z;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic signed [31:0] vert_c_z;
  } pit_in_t;

  typedef struct packed {
    logic                 inside_res;
    logic signed [QW-1:0] coord_u;
    logic signed [QW-1:0] coord_v;
    logic                 degenerate;
  } pit_out_t;

endpackage

// File: hw/rtl/pit_fifo.sv
// Small register FIFO; Depth must be a power of two.
// Overflow is prevented by the caller's credit counting. No package use.
`timescale 1ns / 1ps

module pit_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);

endmodule

// File: hw/rtl/pit_front.sv
// Front end: edge vectors from vertex A and the five dot products, 3 stages.
// Uses pit_pkg::pit_in_t for the input beat.
`timescale 1ns / 1ps

module pit_front #(
  parameter int unsigned CoordW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  pit_pkg::pit_in_t      data_i,
  output logic                  valid_o,
  output logic [5*(2*CoordW+4)-1:0] dots_o
);

  localparam int unsigned DW = CoordW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;

  function automatic logic signed [DW-1:0] ext(input logic signed [31:0] f);
    logic [CoordW-1:0] c;
    c = CoordW'($unsigned(f));
    return DW'($signed(c));
  endfunction

  logic [2:0] vld_q;

  logic signed [CoordW:0] pa [3];
  logic signed [CoordW:0] pb [3];
  logic signed [CoordW:0] pc [3];
  logic signed [CoordW:0] pp [3];

  logic signed [DW-1:0] e0_q [3];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] w_q  [3];
  logic signed [DW-1:0] opa  [5][3];
  logic signed [DW-1:0] opb  [5][3];
  logic signed [PW-1:0] prod_d [5][3];
  logic signed [PW-1:0] prod_q [5][3];
  logic signed [SW-1:0] dot_d [5];
  logic signed [SW-1:0] dot_q [5];

  assign pp[0] = ext(data_i.point_x);
  assign pp[1] = ext(data_i.point_y);
  assign pp[2] = ext(data_i.point_z);
  assign pa[0] = ext(data_i.vert_a_x);
  assign pa[1] = ext(data_i.vert_a_y);
  assign pa[2] = ext(data_i.vert_a_z);
  assign pb[0] = ext(data_i.vert_b_x);
  assign pb[1] = ext(data_i.vert_b_y);
  assign pb[2] = ext(data_i.vert_b_z);
  assign pc[0] = ext(data_i.vert_c_x);
  assign pc[1] = ext(data_i.vert_c_y);
  assign pc[2] = ext(data_i.vert_c_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Operand pairs: e0.e0, e0.e1, e0.w, e1.e1, e1.w
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opa[0][k] = e0_q[k]; opb[0][k] = e0_q[k];
      opa[1][k] = e0_q[k]; opb[1][k] = e1_q[k];
      opa[2][k] = e0_q[k]; opb[2][k] = w_q[k];
      opa[3][k] = e1_q[k]; opb[3][k] = e1_q[k];
      opa[4][k] = e1_q[k]; opb[4][k] = w_q[k];
    end
    for (int j = 0; j < 5; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[j][k] = opa[j][k] * opb[j][k];
      end
      dot_d[j] = SW'(prod_q[j][0]) + SW'(prod_q[j][1]) + SW'(prod_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e0_q[k] <= DW'(pc[k] - pa[k]);
      e1_q[k] <= DW'(pb[k] - pa[k]);
      w_q[k]  <= DW'(pp[k] - pa[k]);
    end
    prod_q <= prod_d;
    dot_q  <= dot_d;
  end

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dots_o[j*SW +: SW] = dot_q[j];
    end
  end

  assign valid_o = vld_q[2];

endmodule

// File: hw/rtl/pit_div.sv
// Pipelined restoring divider: round(n * 2^16 / den) saturated to Q3.16.
// One quotient bit per stage; uses pit_pkg constants.
`timescale 1ns / 1ps

module pit_div #(
  parameter int unsigned NumW = 16
) (
  input  logic                        clk_i,
  input  logic signed [NumW-1:0]      num_i,
  input  logic signed [NumW-1:0]      den_i,
  output logic signed [pit_pkg::QW-1:0] q_o
);

  localparam int unsigned QuoW = pit_pkg::QuoW;
  localparam int unsigned RW   = NumW + QuoW + 1;

  logic [RW-1:0]   r_q   [QuoW+1];
  logic [QuoW-1:0] q_q   [QuoW+1];
  logic [NumW-1:0] dv_q  [QuoW+1];
  logic            neg_q [QuoW+1];
  logic            sat_q [QuoW+1];

  logic [NumW-1:0] mag;
  logic [RW-1:0]   r0;
  logic [NumW-1:0] dv;

  assign mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign dv  = NumW'($unsigned(den_i));
  assign r0  = RW'(mag) << pit_pkg::FracW;

  always_ff @(posedge clk_i) begin
    r_q[0]   <= r0;
    q_q[0]   <= '0;
    dv_q[0]  <= dv;
    neg_q[0] <= num_i[NumW-1];
    sat_q[0] <= (r0 >= (RW'(dv) << QuoW));
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_step
    localparam int unsigned Bit = QuoW - 1 - s;
    logic [RW-1:0] t;
    logic          ge;
    assign t  = RW'(dv_q[s]) << Bit;
    assign ge = (r_q[s] >= t);
    always_ff @(posedge clk_i) begin
      r_q[s+1]   <= ge ? r_q[s] - t : r_q[s];
      q_q[s+1]   <= q_q[s] | (QuoW'(ge) << Bit);
      dv_q[s+1]  <= dv_q[s];
      neg_q[s+1] <= neg_q[s];
      sat_q[s+1] <= sat_q[s];
    end
  end

  // Round half away from zero on the magnitude, then sign and clamp
  logic            rnd;
  logic [QuoW:0]   qr;
  logic signed [pit_pkg::QW-1:0] q_d;

  assign rnd = ((r_q[QuoW] << 1) >= RW'(dv_q[QuoW]));
  assign qr  = (QuoW+1)'(q_q[QuoW]) + (QuoW+1)'(rnd);

  always_comb begin
    if (sat_q[QuoW]) begin
      q_d = neg_q[QuoW] ? pit_pkg::QMin : pit_pkg::QMax;
    end else if (!neg_q[QuoW]) begin
      q_d = (qr > (QuoW+1)'(pit_pkg::QMax)) ? pit_pkg::QMax : pit_pkg::QW'(qr);
    end else begin
      q_d = (qr > (QuoW+1)'(pit_pkg::QNegMag)) ? pit_pkg::QMin : -pit_pkg::QW'(qr);
    end
  end

  always_ff @(posedge clk_i) begin
    q_o <= q_d;
  end

endmodule

// File: hw/rtl/pit_back.sv
// Back end: wide cross products (split multipliers), den/nu/nv, inside test
// and two pit_div dividers. Uses pit_pkg.
`timescale 1ns / 1ps

module pit_back #(
  parameter int unsigned CoordW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      issue_i,
  input  logic [5*(2*CoordW+4)-1:0] dots_i,
  output logic                      valid_o,
  output pit_pkg::pit_out_t         res_o
);

  localparam int unsigned SW   = 2 * CoordW + 4;
  localparam int unsigned H    = (SW + 1) / 2;
  localparam int unsigned HiW  = SW - H;
  localparam int unsigned PPW  = 2 * H + 2;
  localparam int unsigned MW   = 2 * SW;
  localparam int unsigned NW   = MW + 1;
  localparam int unsigned Lat  = pit_pkg::DivLat;

  // dot product slots as packed by the front end
  localparam int unsigned D00 = 0;
  localparam int unsigned D01 = 1;
  localparam int unsigned D02 = 2;
  localparam int unsigned D11 = 3;
  localparam int unsigned D12 = 4;

  typedef struct packed {
    logic vld;
    logic in_tri;
    logic degen;
  } pit_flag_t;

  logic signed [SW-1:0]  d    [5];
  logic signed [SW-1:0]  opa  [6];
  logic signed [SW-1:0]  opb  [6];
  logic signed [PPW-1:0] pp_d [6][4];
  logic signed [PPW-1:0] pp_q [6][4];
  logic signed [MW-1:0]  prod_d [6];
  logic signed [MW-1:0]  prod_q [6];
  logic signed [NW-1:0]  den_q, nu_q, nv_q;
  logic [2:0]            vld_q;
  pit_flag_t             fl_d;
  pit_flag_t             fl_q [Lat];
  logic signed [pit_pkg::QW-1:0] qu, qv;

  for (genvar j = 0; j < 5; j++) begin : g_dot
    assign d[j] = $signed(dots_i[j*SW +: SW]);
  end

  // den = d00*d11 - d01*d01, nu = d11*d02 - d01*d12, nv = d00*d12 - d01*d02
  assign opa[0] = d[D00]; assign opb[0] = d[D11];
  assign opa[1] = d[D01]; assign opb[1] = d[D01];
  assign opa[2] = d[D11]; assign opb[2] = d[D02];
  assign opa[3] = d[D01]; assign opb[3] = d[D12];
  assign opa[4] = d[D00]; assign opb[4] = d[D12];
  assign opa[5] = d[D01]; assign opb[5] = d[D02];

  always_comb begin
    logic [H-1:0]          al, bl;
    logic signed [HiW-1:0] ah, bh;
    for (int m = 0; m < 6; m++) begin
      al = opa[m][H-1:0];
      bl = opb[m][H-1:0];
      ah = $signed(opa[m][SW-1:H]);
      bh = $signed(opb[m][SW-1:H]);
      pp_d[m][0] = $signed(PPW'(al) * PPW'(bl));
      pp_d[m][1] = $signed({1'b0, al}) * bh;
      pp_d[m][2] = ah * $signed({1'b0, bl});
      pp_d[m][3] = ah * bh;
    end
    for (int m = 0; m < 6; m++) begin
      prod_d[m] = (MW'(pp_q[m][3]) <<< (2 * H))
                + ((MW'(pp_q[m][1]) + MW'(pp_q[m][2])) <<< H)
                + MW'(pp_q[m][0]);
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    prod_q <= prod_d;
    den_q  <= NW'(prod_q[0]) - NW'(prod_q[1]);
    nu_q   <= NW'(prod_q[2]) - NW'(prod_q[3]);
    nv_q   <= NW'(prod_q[4]) - NW'(prod_q[5]);
  end

  // Inside test on the exact rationals; den >= 0 by construction
  always_comb begin
    logic signed [NW:0] sum;
    sum          = (NW+1)'(nu_q) + (NW+1)'(nv_q);
    fl_d.vld     = vld_q[2];
    fl_d.degen   = (den_q <= 0);
    fl_d.in_tri  = !fl_d.degen && !nu_q[NW-1] && !nv_q[NW-1]
                 && (sum <= (NW+1)'(den_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int i = 0; i < Lat; i++) begin
        fl_q[i] <= '0;
      end
    end else begin
      vld_q   <= {vld_q[1:0], issue_i};
      fl_q[0] <= fl_d;
      for (int i = 1; i < Lat; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  pit_div #(.NumW(NW)) u_div_u (
    .clk_i (clk_i),
    .num_i (nu_q),
    .den_i (den_q),
    .q_o   (qu)
  );

  pit_div #(.NumW(NW)) u_div_v (
    .clk_i (clk_i),
    .num_i (nv_q),
    .den_i (den_q),
    .q_o   (qv)
  );

  assign valid_o          = fl_q[Lat-1].vld;
  assign res_o.inside_res = fl_q[Lat-1].in_tri;
  assign res_o.degenerate = fl_q[Lat-1].degen;
  assign res_o.coord_u    = fl_q[Lat-1].degen ? '0 : qu;
  assign res_o.coord_v    = fl_q[Lat-1].degen ? '0 : qv;

endmodule

// File: hw/rtl/point_in_triangle_barycentric.sv
// Top level: barycentric point-in-triangle test.
// Instantiates pit_front, pit_fifo (twice), pit_back; uses pit_pkg.
//
// Usage:
//   Input channel is a queue write port: a beat (point P, vertices A, B, C,
//   signed Q15.16) is taken on a rising edge with push high and full low.
//   Result channel is a queue read port: while empty is low the oldest
//   result (inside flag, u and v in signed Q3.16, degenerate flag) sits on
//   out_data_o and leaves on a rising edge with pop high.
//   Throughput: one beat per cycle, sustained while results are drained.
//   Path: the accepted beat passes the 3-stage front end, the mid queue
//   hand-off, 3 multiply stages and the 23-stage divider (one quotient bit
//   per stage), then the result queue, before empty goes low.
//   Front and back run on credits: full rises once 8 beats sit in the front
//   end and mid queue; the back end issues only while the 32-entry result
//   queue has room, so a stalled receiver fills the result queue, then the
//   mid queue, then raises full. Nothing is dropped.
//   Reset (rst_ni low, asynchronous) empties every queue and pipeline.
`timescale 1ns / 1ps

module point_in_triangle_barycentric #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pit_pkg::pit_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output pit_pkg::pit_out_t out_data_o
);

  localparam int unsigned DotsW = 5 * (2 * COORD_WIDTH + 4);
  localparam int unsigned MidD  = pit_pkg::MidDepth;
  localparam int unsigned OutD  = pit_pkg::OutDepth;
  localparam int unsigned MCW   = $clog2(MidD + 1);
  localparam int unsigned OCW   = $clog2(OutD + 1);
  localparam int unsigned ResW  = $bits(pit_pkg::pit_out_t);

  logic             accept, out_pop, issue;
  logic             fr_vld, bk_vld, mid_empty;
  logic [DotsW-1:0] fr_dots, mid_dots;
  pit_pkg::pit_out_t bk_res;
  logic [ResW-1:0]  out_raw;
  logic [MCW-1:0]   mid_cred_q, mid_cred_d;
  logic [OCW-1:0]   out_cred_q, out_cred_d;

  assign accept  = push && !full;
  assign out_pop = pop && !empty;
  assign full    = (mid_cred_q == MCW'(MidD));
  assign issue   = !mid_empty && (out_cred_q != OCW'(OutD));

  assign mid_cred_d = mid_cred_q + MCW'(accept) - MCW'(issue);
  assign out_cred_d = out_cred_q + OCW'(issue) - OCW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_cred_q <= '0;
      out_cred_q <= '0;
    end else begin
      mid_cred_q <= mid_cred_d;
      out_cred_q <= out_cred_d;
    end
  end

  pit_front #(.CoordW(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .data_i  (in_data_i),
    .valid_o (fr_vld),
    .dots_o  (fr_dots)
  );

  pit_fifo #(.Width(DotsW), .Depth(MidD)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_vld),
    .data_i  (fr_dots),
    .pop_i   (issue),
    .data_o  (mid_dots),
    .empty_o (mid_empty)
  );

  pit_back #(.CoordW(COORD_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .dots_i  (mid_dots),
    .valid_o (bk_vld),
    .res_o   (bk_res)
  );

  pit_fifo #(.Width(ResW), .Depth(OutD)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_vld),
    .data_i  (bk_res),
    .pop_i   (out_pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_data_o = out_raw;

  a_mid_cred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_cred_q <= MCW'(MidD))
    else $error("mid credit count exceeds queue depth");

  a_out_cred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cred_q <= OCW'(OutD))
    else $error("result credit count exceeds queue depth");

  a_mid_has_cred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mid_empty |-> mid_cred_q != '0)
    else $error("mid queue holds a beat without a credit");

  a_out_has_cred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_cred_q != '0)
    else $error("result queue holds a beat without a credit");

endmodule
